// File: sv/piecewise_linear_evaluator_defines.svh
// Assertion macros used by the piecewise linear evaluator checker.
`ifndef PIECEWISE_LINEAR_EVALUATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_EVALUATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PLE_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ple: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ple: next-cycle check failed");

`endif

// File: sv/ple_pkg.sv
// Types, constants and control store of the piecewise linear evaluator.
package ple_pkg;

	localparam int VAL_W      = 16;   // Q8.8 times and values
	localparam int PIDX_W     = 4;    // point_index and segment_index
	localparam int NUM_W      = 5;    // num_points register
	localparam int STEP_W     = 4;    // sequencer step counter
	localparam int DCNT_W     = 4;    // divider iteration counter
	localparam int IN_DATA_W  = 56;   // 52 payload bits padded to bytes
	localparam int OUT_DATA_W = 24;   // 20 payload bits padded to bytes

	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(VAL_W - 1);

	typedef logic [STEP_W-1:0] step_t;

	// Request kinds carried on the input tuser bit
	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_EVAL  = 1'b1
	} req_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_IDLE       = 4'd0,
		OP_RD_CUR     = 4'd1,
		OP_TAKE_FIRST = 4'd2,
		OP_RD_NEXT    = 4'd3,
		OP_TAKE_NEXT  = 4'd4,
		OP_NOP        = 4'd5,
		OP_ADVANCE    = 4'd6,
		OP_DIFF       = 4'd7,
		OP_MUL        = 4'd8,
		OP_DIV        = 4'd9,
		OP_FINISH     = 4'd10,
		OP_HOLD       = 4'd11
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER    = 3'd0,
		C_ALWAYS   = 3'd1,
		C_NO_START = 3'd2,
		C_SINGLE   = 3'd3,
		C_INSIDE   = 3'd4,
		C_AT_END   = 3'd5,
		C_DIV_BUSY = 3'd6
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  needs_out;  // step writes the output register
	} cword_t;

	typedef struct packed {
		logic start;
		logic single;
		logic in_seg;
		logic at_end;
		logic div_busy;
	} flags_t;

	// Step numbers that are jump targets
	localparam step_t ST_IDLE = 4'd0;
	localparam step_t ST_TEST = 4'd5;
	localparam step_t ST_MATH = 4'd8;
	localparam step_t ST_DIV  = 4'd10;
	localparam step_t ST_HOLD = 4'd12;

	function automatic cword_t ucode(input step_t step);
		cword_t w;
		w = '{op: OP_IDLE, cond: C_NO_START, target: ST_IDLE, needs_out: 1'b0};
		unique case (step)
			4'd0:  w = '{op: OP_IDLE,       cond: C_NO_START, target: ST_IDLE, needs_out: 1'b0};
			4'd1:  w = '{op: OP_RD_CUR,     cond: C_NEVER,    target: ST_IDLE, needs_out: 1'b0};
			4'd2:  w = '{op: OP_TAKE_FIRST, cond: C_SINGLE,   target: ST_HOLD, needs_out: 1'b0};
			4'd3:  w = '{op: OP_RD_NEXT,    cond: C_NEVER,    target: ST_IDLE, needs_out: 1'b0};
			4'd4:  w = '{op: OP_TAKE_NEXT,  cond: C_NEVER,    target: ST_IDLE, needs_out: 1'b0};
			4'd5:  w = '{op: OP_NOP,        cond: C_INSIDE,   target: ST_MATH, needs_out: 1'b0};
			4'd6:  w = '{op: OP_ADVANCE,    cond: C_AT_END,   target: ST_HOLD, needs_out: 1'b0};
			4'd7:  w = '{op: OP_TAKE_NEXT,  cond: C_ALWAYS,   target: ST_TEST, needs_out: 1'b0};
			4'd8:  w = '{op: OP_DIFF,       cond: C_NEVER,    target: ST_IDLE, needs_out: 1'b0};
			4'd9:  w = '{op: OP_MUL,        cond: C_NEVER,    target: ST_IDLE, needs_out: 1'b0};
			4'd10: w = '{op: OP_DIV,        cond: C_DIV_BUSY, target: ST_DIV,  needs_out: 1'b0};
			4'd11: w = '{op: OP_FINISH,     cond: C_ALWAYS,   target: ST_IDLE, needs_out: 1'b1};
			4'd12: w = '{op: OP_HOLD,       cond: C_ALWAYS,   target: ST_IDLE, needs_out: 1'b1};
			default: w = '{op: OP_IDLE, cond: C_ALWAYS, target: ST_IDLE, needs_out: 1'b0};
		endcase
		return w;
	endfunction

endpackage

// File: sv/ple_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
module ple_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  ple_pkg::flags_t     flags,
	input  logic                out_free,
	output ple_pkg::cword_t     cw
);

	ple_pkg::step_t step_q;
	logic           taken;
	logic           stall;

	assign cw    = ple_pkg::ucode(step_q);
	// hold a step that writes the output register while a result is still pending
	assign stall = cw.needs_out && !out_free;

	always_comb begin
		unique case (cw.cond)
			ple_pkg::C_NEVER:    taken = 1'b0;
			ple_pkg::C_ALWAYS:   taken = 1'b1;
			ple_pkg::C_NO_START: taken = !flags.start;
			ple_pkg::C_SINGLE:   taken = flags.single;
			ple_pkg::C_INSIDE:   taken = flags.in_seg;
			ple_pkg::C_AT_END:   taken = flags.at_end;
			ple_pkg::C_DIV_BUSY: taken = flags.div_busy;
			default:             taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ple_pkg::ST_IDLE;
		end else if (!stall) begin
			if (taken) begin
				step_q <= cw.target;
			end else begin
				step_q <= step_q + ple_pkg::step_t'(1);
			end
		end
	end

endmodule

// File: sv/piecewise_linear_evaluator.sv
// Top level of the piecewise linear evaluator: breakpoint table and datapath.
//
//  channel  dir  handshake                      payload
//  -------  ---  -----------------------------  ------------------------------------------
//  s_axis   in   s_axis_tvalid / s_axis_tready  tuser: req_type; tdata: index, x, y, time
//  m_axis   out  m_axis_tvalid / m_axis_tready  tuser: segment_found; tdata: value, index
//  cfg      in   cfg_we (no wait)               cfg_wdata: num_points
//
//  A breakpoint write is stored while idle and the block stays ready for the next item.
//  An evaluation with one point in use returns the y of entry 0. Otherwise it scans
//  the segments in order through the single table read port until one matches, then
//  runs the difference, 16x16 multiply, 16 restoring division steps and final add;
//  the divider yields one bit per cycle. With no match it ends at the last segment.
//  Reset clears the sequencer, num_points (to 1) and the output valid; the table
//  holds whatever was written. A stalled result holds in the output register;
//  the next evaluation runs meanwhile and waits only at its final step.
module piecewise_linear_evaluator #(
	parameter int MAX_POINTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: num_points
	input  logic                                cfg_we,
	input  logic [ple_pkg::NUM_W-1:0]           cfg_wdata,
	// input items
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [3:0] point_index, [19:4] point_x, [35:20] point_y, [51:36] query_time
	input  logic [ple_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// [0] req_type
	input  logic                                s_axis_tuser,
	// results
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] value, [19:16] segment_index
	output logic [ple_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// [0] segment_found
	output logic                                m_axis_tuser
);

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int VW = ple_pkg::VAL_W;

	// Unpacked input fields
	logic [ple_pkg::PIDX_W-1:0] point_index;
	logic [VW-1:0]              point_x;
	logic signed [VW-1:0]       point_y;
	logic [VW-1:0]              query_time;

	assign point_index = s_axis_tdata[3:0];
	assign point_x     = s_axis_tdata[19:4];
	assign point_y     = s_axis_tdata[35:20];
	assign query_time  = s_axis_tdata[51:36];

	// Configuration register
	logic [ple_pkg::NUM_W-1:0] num_points_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= ple_pkg::NUM_W'(1);
		end else if (cfg_we) begin
			num_points_q <= cfg_wdata;
		end
	end

	// Sequencer
	ple_pkg::cword_t cw;
	ple_pkg::flags_t flags;
	logic            out_free;
	logic            m_valid_q;

	ple_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags    (flags),
		.out_free (out_free),
		.cw       (cw)
	);

	// Input handshake: items are taken only while the sequencer idles
	logic s_fire;
	logic eval_start;
	logic wr_fire;

	assign s_axis_tready = (cw.op == ple_pkg::OP_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign eval_start    = s_fire && (s_axis_tuser == ple_pkg::REQ_EVAL);
	assign wr_fire       = s_fire && (s_axis_tuser == ple_pkg::REQ_WRITE)
	                       && (32'(point_index) < MAX_POINTS);

	// Breakpoint table, {y, x} per entry, one write and one registered read port
	logic [2*VW-1:0] table_mem [MAX_POINTS];
	logic [2*VW-1:0] rdata_q;
	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   last_q;

	always_comb begin
		unique case (cw.op)
			ple_pkg::OP_RD_NEXT: rd_addr = IW'(idx_q + IW'(1));
			ple_pkg::OP_ADVANCE: rd_addr = IW'(idx_q + IW'(2));  // next-but-one: idx moves too
			default:             rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			table_mem[IW'(point_index)] <= {point_y, point_x};
		end
		rdata_q <= table_mem[rd_addr];
	end

	// Last point in use: num_points clamped to 1..MAX_POINTS, minus one
	logic [IW-1:0]             last_d;
	logic [ple_pkg::NUM_W-1:0] num_m1;

	assign num_m1 = num_points_q - ple_pkg::NUM_W'(1);

	always_comb begin
		priority if (num_points_q == '0) begin
			last_d = '0;
		end else if (32'(num_points_q) > MAX_POINTS) begin
			last_d = IW'(MAX_POINTS - 1);
		end else begin
			last_d = IW'(num_m1);
		end
	end

	// Datapath registers
	logic [VW-1:0]           t_q;
	logic [VW-1:0]           prev_x_q;
	logic signed [VW-1:0]    prev_y_q;
	logic [VW-1:0]           cur_x_q;
	logic signed [VW-1:0]    cur_y_q;
	logic [VW-1:0]           ofs_q;     // t - x_i
	logic [VW-1:0]           dmag_q;    // |y_{i+1} - y_i|
	logic                    neg_q;
	logic [VW-1:0]           dx_q;
	logic [VW-1:0]           rem_q;
	logic [VW-1:0]           quo_q;
	logic [ple_pkg::DCNT_W-1:0] cnt_q;

	logic signed [VW:0]      dy;
	logic [VW:0]             dy_abs;
	logic [2*VW-1:0]         prod;
	logic [VW:0]             trial;
	logic                    fits;
	logic signed [VW+1:0]    qsgn;
	logic signed [VW+1:0]    sum;

	assign dy     = (VW+1)'(cur_y_q) - (VW+1)'(prev_y_q);
	assign dy_abs = dy[VW] ? (VW+1)'(-dy) : (VW+1)'(dy);
	assign prod   = (2*VW)'(ofs_q) * (2*VW)'(dmag_q);
	// restoring step: shift in the next dividend bit, try subtracting the divisor
	assign trial  = {rem_q, quo_q[VW-1]};
	assign fits   = (trial >= {1'b0, dx_q});
	assign qsgn   = neg_q ? -(VW+2)'(signed'({2'b00, quo_q})) : (VW+2)'(signed'({2'b00, quo_q}));
	assign sum    = (VW+2)'(prev_y_q) + qsgn;

	always_ff @(posedge clk) begin
		unique case (cw.op)
			ple_pkg::OP_IDLE: begin
				if (eval_start) begin
					t_q <= query_time;
				end
			end
			ple_pkg::OP_TAKE_FIRST: begin
				prev_x_q <= rdata_q[VW-1:0];
				prev_y_q <= rdata_q[2*VW-1:VW];
				cur_x_q  <= rdata_q[VW-1:0];
				cur_y_q  <= rdata_q[2*VW-1:VW];
			end
			ple_pkg::OP_TAKE_NEXT: begin
				cur_x_q <= rdata_q[VW-1:0];
				cur_y_q <= rdata_q[2*VW-1:VW];
			end
			ple_pkg::OP_ADVANCE: begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
			end
			ple_pkg::OP_DIFF: begin
				ofs_q  <= t_q - prev_x_q;
				dx_q   <= cur_x_q - prev_x_q;
				dmag_q <= dy_abs[VW-1:0];
				neg_q  <= dy[VW];
			end
			ple_pkg::OP_MUL: begin
				// high half is below dx since t - x_i < dx
				rem_q <= prod[2*VW-1:VW];
				quo_q <= prod[VW-1:0];
			end
			ple_pkg::OP_DIV: begin
				rem_q <= fits ? VW'(trial - {1'b0, dx_q}) : trial[VW-1:0];
				quo_q <= {quo_q[VW-2:0], fits};
			end
			default: begin
			end
		endcase
	end

	// Control registers of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			last_q <= '0;
			cnt_q  <= '0;
		end else begin
			unique case (cw.op)
				ple_pkg::OP_IDLE: begin
					if (eval_start) begin
						idx_q  <= '0;
						last_q <= last_d;
					end
				end
				ple_pkg::OP_ADVANCE: idx_q <= IW'(idx_q + IW'(1));
				ple_pkg::OP_MUL:     cnt_q <= '0;
				ple_pkg::OP_DIV:     cnt_q <= cnt_q + ple_pkg::DCNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	// Jump conditions
	assign flags.start    = eval_start;
	assign flags.single   = (last_q == '0);
	assign flags.in_seg   = (prev_x_q <= t_q) && (t_q < cur_x_q);
	assign flags.at_end   = ({1'b0, idx_q} + (IW+1)'(1)) == {1'b0, last_q};
	assign flags.div_busy = (cnt_q != ple_pkg::DIV_LAST);

	// Output register
	logic                       out_load;
	logic signed [VW-1:0]       value_q;
	logic                       found_q;
	logic [ple_pkg::PIDX_W-1:0] seg_q;

	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = cw.needs_out && out_free;

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cw.op == ple_pkg::OP_FINISH) begin
				value_q <= sum[VW-1:0];
				found_q <= 1'b1;
				seg_q   <= ple_pkg::PIDX_W'(idx_q);
			end else begin
				value_q <= cur_y_q;
				found_q <= 1'b0;
				seg_q   <= ple_pkg::PIDX_W'(last_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0000, seg_q, value_q};
	assign m_axis_tuser  = found_q;

endmodule

// File: sv/ple_chk.sv
// Port-level checker for the piecewise linear evaluator, bound to the top level.
`include "piecewise_linear_evaluator_defines.svh"

module ple_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ple_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tuser
);

	logic eval_acc;
	logic wr_acc;

	assign eval_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ple_pkg::REQ_EVAL);
	assign wr_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ple_pkg::REQ_WRITE);

	// a stalled result holds
	`PLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// an evaluation occupies the block
	`PLE_ASSERT_NEXT(a_eval_busy, eval_acc, !s_axis_tready)
	// a breakpoint write leaves the block ready
	`PLE_ASSERT_NEXT(a_write_quick, wr_acc, s_axis_tready)
	// no result appears the cycle after an evaluation is taken
	`PLE_ASSERT_NEXT(a_no_instant, eval_acc && !m_axis_tvalid, !m_axis_tvalid)
	// padding bits of the result stay zero
	`PLE_ASSERT_IMPLY(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:20] == 4'b0000)

endmodule

bind piecewise_linear_evaluator ple_chk u_ple_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: verif/piecewise_linear_evaluator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise linear evaluator: table writes, evaluations, backpressure.
module piecewise_linear_evaluator_tb;

	localparam int RESET_CYCLES     = 12;
	localparam int TABLE_DEPTH      = 16;
	// Longest evaluation scans every segment and then divides; leave margin
	localparam int SETTLE_CYCLES    = 100;
	localparam int LIMIT_CYCLES     = 800000;
	localparam int MAX_REPORTS      = 10;
	localparam int ROUNDS_PER_PHASE = 3;
	localparam int ITEMS_PER_ROUND  = 28;
	localparam int HOLDOFF_CYCLES   = 400;

	typedef struct packed {
		logic [15:0] value;
		logic        found;
		logic [3:0]  seg;
	} pl_result_t;

	typedef enum int {
		SHAPE_RISING,     // strictly ascending abscissae
		SHAPE_PLATEAUS,   // ascending with repeated abscissae (zero-width segments)
		SHAPE_SCRAMBLED   // abscissae in no order at all
	} table_shape_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ple_pkg::NUM_W-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [ple_pkg::IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [ple_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	// Predictor state: breakpoint table and raw point-count register
	logic [15:0] bp_x [TABLE_DEPTH];
	logic [15:0] bp_y [TABLE_DEPTH];
	logic [4:0]  point_count_reg = 5'd1;

	pl_result_t expected_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_len    = 0;
	int holdoff_seq    = 0;
	int holdoff_seen   = 0;
	int holdoff_left   = 0;

	int error_count     = 0;
	int items_sent      = 0;
	int writes_sent     = 0;
	int results_checked = 0;
	int settings_used   = 0;
	int cycle_count     = 0;

	piecewise_linear_evaluator #(
		.MAX_POINTS(TABLE_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still awaited",
				cycle_count, expected_results.size());
			$display("piecewise_linear_evaluator_tb NOT OK");
			$finish;
		end
	end

	// Zero and oversized counts fold into 1..16
	function automatic int points_in_use();
		if (point_count_reg == 0)
			return 1;
		if (point_count_reg > TABLE_DEPTH)
			return TABLE_DEPTH;
		return int'(point_count_reg);
	endfunction

	// First segment with x_i <= t < x_i+1 wins; otherwise hold the last y
	function automatic pl_result_t interpolate_at(input logic [15:0] t);
		pl_result_t r;
		int n;
		longint dx;
		longint dy;
		longint q;
		n = points_in_use();
		r.value = bp_y[n-1];
		r.found = 1'b0;
		r.seg   = 4'(n - 1);
		for (int i = 0; i + 1 < n; i++) begin
			if (bp_x[i] <= t && t < bp_x[i+1]) begin
				dx = longint'(bp_x[i+1]) - longint'(bp_x[i]);
				dy = longint'($signed(bp_y[i+1])) - longint'($signed(bp_y[i]));
				// SV division truncates toward zero, as the block must
				q = ((longint'(t) - longint'(bp_x[i])) * dy) / dx;
				r.value = 16'(longint'($signed(bp_y[i])) + q);
				r.found = 1'b1;
				r.seg   = 4'(i);
				break;
			end
		end
		return r;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	// Receiver: random stalls, plus a long hold-off when the test asks for one
	always @(posedge clk) begin
		if (holdoff_seq != holdoff_seen) begin
			holdoff_seen  <= holdoff_seq;
			holdoff_left  <= holdoff_len;
			m_axis_tready <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left  <= holdoff_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare every result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		pl_result_t got;
		pl_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.value = m_axis_tdata[15:0];
			got.found = m_axis_tuser;
			got.seg   = m_axis_tdata[19:16];
			if (expected_results.size() == 0) begin
				flag_error($sformatf("result with nothing expected: value=%0d found=%0b seg=%0d",
					$signed(got.value), got.found, got.seg));
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (got !== want)
					flag_error($sformatf({"expected value=%0d found=%0b seg=%0d, ",
						"got value=%0d found=%0b seg=%0d"},
						$signed(want.value), want.found, want.seg,
						$signed(got.value), got.found, got.seg));
			end
		end
	end

	// Offer one input transaction, idling first at random; predict on acceptance
	task automatic send_item(input ple_pkg::req_t kind, input logic [3:0] pidx,
			input logic [15:0] px, input logic [15:0] py, input logic [15:0] qt);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'b0, qt, py, px, pidx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (kind == ple_pkg::REQ_WRITE) begin
			bp_x[pidx] = px;
			bp_y[pidx] = py;
			writes_sent++;
		end else begin
			expected_results.push_back(interpolate_at(qt));
		end
	endtask

	// Unused fields carry random bits so every payload bit toggles
	task automatic write_point(input logic [3:0] pidx, input logic [15:0] px,
			input logic [15:0] py);
		send_item(ple_pkg::REQ_WRITE, pidx, px, py, 16'($urandom));
	endtask

	task automatic evaluate(input logic [15:0] t);
		send_item(ple_pkg::REQ_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), t);
	endtask

	// Drop valid, wait for every result, then let any trailing write finish
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_point_count(input logic [4:0] n);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		point_count_reg = n;
		settings_used++;
	endtask

	// Rewrite all sixteen entries so no unwritten entry can ever be read
	task automatic load_table(input table_shape_t shape);
		logic [15:0] x;
		logic [15:0] y;
		x = 16'($urandom_range(2000));
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			case ($urandom_range(7))
				0: y = 16'h8000;
				1: y = 16'h7FFF;
				default: y = 16'($urandom);
			endcase
			write_point(4'(i), (shape == SHAPE_SCRAMBLED) ? 16'($urandom) : x, y);
			if (shape == SHAPE_PLATEAUS)
				x = x + 16'($urandom_range(3000));
			else if ($urandom_range(3) == 0)
				x = x + 16'($urandom_range(3, 1));
			else
				x = x + 16'($urandom_range(3900, 1));
		end
	endtask

	function automatic logic [4:0] pick_count();
		case ($urandom_range(9))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd31;
			3: return 5'(17 + $urandom_range(14));
			4: return 5'd16;
			default: return 5'($urandom_range(16, 2));
		endcase
	endfunction

	// Aim mostly at breakpoints and the span of the table, rest anywhere
	function automatic logic [15:0] pick_query_time();
		int n;
		int k;
		logic [15:0] lo;
		logic [15:0] hi;
		n  = points_in_use();
		k  = $urandom_range(n - 1);
		lo = bp_x[0];
		hi = bp_x[n-1];
		if (lo > hi) begin
			lo = bp_x[n-1];
			hi = bp_x[0];
		end
		case ($urandom_range(9))
			0, 1, 2, 3: return bp_x[k] + 16'($urandom_range(4)) - 16'd2;
			4, 5, 6: return 16'($urandom_range(hi, lo));
			7: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Reset count of one: only entry 0 is read, zero count behaves the same
	task automatic test_single_point();
		write_point(4'd0, 16'h1234, 16'h8000);
		evaluate(16'h0000);
		evaluate(16'hFFFF);
		set_point_count(5'd0);
		evaluate(16'h1234);
	endtask

	// Full-range segment, extreme values, and a falling ramp whose quotient
	// is negative and inexact, so truncation toward zero shows
	task automatic test_extremes();
		write_point(4'd0, 16'h0000, 16'h8000);
		write_point(4'd1, 16'hFFFF, 16'h7FFF);
		set_point_count(5'd2);
		evaluate(16'h0000);
		evaluate(16'hFFFE);
		evaluate(16'hFFFF);
		write_point(4'd0, 16'h0100, 16'h7FFF);
		write_point(4'd1, 16'h0104, 16'h8000);
		evaluate(16'h0101);
		evaluate(16'h0103);
		evaluate(16'h00FF);
	endtask

	// Oversized counts fold to sixteen; the table holds a zero-width segment
	// at entry 4 and a descending step at entry 8
	task automatic test_count_clamp();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			case (i)
				5: write_point(4'(i), 16'h4000, 16'($urandom));
				9: write_point(4'(i), 16'h7000, 16'($urandom));
				default: write_point(4'(i), 16'(i * 16'h1000), 16'($urandom));
			endcase
		end
		set_point_count(5'd31);
		evaluate(16'h4000);
		evaluate(16'h8800);
		evaluate(16'hFFFF);
		set_point_count(5'd17);
		evaluate(16'h0800);
		set_point_count(5'd16);
		evaluate(16'hF000);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct);
		table_shape_t shape;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (ROUNDS_PER_PHASE) begin
			set_point_count(pick_count());
			case ($urandom_range(9))
				0, 1: shape = SHAPE_PLATEAUS;
				2: shape = SHAPE_SCRAMBLED;
				default: shape = SHAPE_RISING;
			endcase
			load_table(shape);
			repeat (ITEMS_PER_ROUND) begin
				// occasional stray write disturbs an otherwise well-formed table
				if ($urandom_range(99) < 8)
					write_point(4'($urandom), 16'($urandom), 16'($urandom));
				else
					evaluate(pick_query_time());
			end
		end
	endtask

	// Hold the output off for a long stretch while evaluations keep coming,
	// so the block fills and stalls its input; then drain fully and resume
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_point_count(5'd16);
		load_table(SHAPE_RISING);
		holdoff_len = HOLDOFF_CYCLES;
		holdoff_seq++;
		repeat (16)
			evaluate(pick_query_time());
		wait_drain();
		repeat (8)
			evaluate(pick_query_time());
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_point();
		test_extremes();
		test_count_clamp();
		test_random_phase(0, 0);
		test_random_phase(48, 0);
		test_random_phase(0, 48);
		test_random_phase(22, 22);
		test_output_backpressure();
		wait_drain();

		$display("covered: %0d transactions in (%0d breakpoint writes), %0d results checked",
			items_sent, writes_sent, results_checked);
		$display("covered: %0d point-count settings, four idle/stall mixes, one long hold-off",
			settings_used);
		if (error_count == 0) begin
			$display("piecewise_linear_evaluator_tb OK");
		end else begin
			$display("%0d mismatches", error_count);
			$display("piecewise_linear_evaluator_tb NOT OK");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/ple_pkg.sv
sv/ple_seq.sv
sv/piecewise_linear_evaluator.sv
sv/ple_chk.sv
verif/piecewise_linear_evaluator_tb.sv
